/* sv/mbrpe_pkg.sv */
// ----------------------------------------------------------------------------
// MBR partition entry encoder package
// Types and constants shared by the partition entry encoder.
// ----------------------------------------------------------------------------
package mbrpe_pkg;

	// Geometry register indexes on the write port.
	localparam logic REG_SECTORS_PER_HEAD   = 1'b0;
	localparam logic REG_HEADS_PER_CYLINDER = 1'b1;

	localparam logic [5:0] SPH_RESET = 6'd32;
	localparam logic [7:0] HPC_RESET = 8'd64;

	// Largest block number that still fits a 32-bit sector address.
	localparam logic [29:0] BLOCK_MAX = 30'h3FFF_FFFF;

	localparam logic [9:0] CYL_MAX      = 10'd1023;
	localparam logic [8:0] TABLE_BASE   = 9'd446;
	localparam logic [8:0] ENTRY_STRIDE = 9'd16;
	localparam logic [7:0] BOOT_NONE    = 8'h00;

	// Quotient bits resolved by the divider pipeline.
	localparam int CYL_BITS   = 10;
	localparam int HEAD_BITS  = 8;
	localparam int DIV_STAGES = CYL_BITS + HEAD_BITS;
	localparam int REM_W      = 24;

	// One CHS conversion in flight.
	typedef struct packed {
		logic                  ovf;
		logic [REM_W-1:0]      rem;
		logic [DIV_STAGES-1:0] quo;
	} lane_t;

	// Fields that ride along with a request unchanged.
	typedef struct packed {
		logic [8:0]  offset;
		logic [7:0]  ptype;
		logic [31:0] first_lba;
		logic [31:0] count;
	} side_t;

endpackage

/* sv/mbr_partition_entry_encoder_unit.sv */
// ----------------------------------------------------------------------------
// MBR partition entry encoder
// Turns one partition request into the fields of a classic MBR table entry.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// Busy is held low: the pipeline takes a new request in every cycle.
// Each request carries the slot, the type byte, and the start and size in
// 2048-byte blocks. The block saturates the start and end block numbers,
// forms the first and last 512-byte sector addresses, and converts both to
// cylinder, head and sector with the geometry in the two write registers.
// The conversion runs through a restoring divider that resolves one
// quotient bit per stage: ten stages for the cylinder, eight for the head.
// A request passes three setup stages, the divider stages and an output
// register; done then pulses for one cycle, and the result is taken at the
// edge that ends that cycle. Sustained throughput is one request per cycle.
// The receiver cannot stall, so no request ever waits inside the block.
// Reset clears all valid bits and loads the default geometry of 32 sectors
// per head and 64 heads per cylinder. The geometry may only be rewritten
// while no request is in flight; stage 3, the divider and the output stage read the live registers.
// ----------------------------------------------------------------------------
module mbr_partition_entry_encoder_unit
	import mbrpe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [7:0]  wr_data,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  slot_number,
	input  logic [7:0]  part_type_in,
	input  logic [31:0] start_block,
	input  logic [31:0] size_blocks,
	output logic        done,
	output logic [8:0]  entry_offset,
	output logic [7:0]  boot_flag,
	output logic [7:0]  first_head,
	output logic [7:0]  start_sec_cylhi,
	output logic [7:0]  start_cyl_low,
	output logic [7:0]  part_type_out,
	output logic [7:0]  last_head,
	output logic [7:0]  end_sec_cylhi,
	output logic [7:0]  end_cyl_low,
	output logic [31:0] first_lba,
	output logic [31:0] lba_count
);

	localparam int LATENCY = 3 + DIV_STAGES + 1;

	// Geometry registers. A zero value is treated as one.
	logic [5:0]  sph_q;
	logic [7:0]  hpc_q;
	logic [5:0]  sph_eff;
	logic [7:0]  hpc_eff;
	logic [13:0] per_cyl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sph_q <= SPH_RESET;
			hpc_q <= HPC_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_SECTORS_PER_HEAD:   sph_q <= wr_data[5:0];
				REG_HEADS_PER_CYLINDER: hpc_q <= wr_data;
				default: ;
			endcase
		end
	end

	assign sph_eff = (sph_q == 6'd0) ? 6'd1 : sph_q;
	assign hpc_eff = (hpc_q == 8'd0) ? 8'd1 : hpc_q;
	assign per_cyl = 14'(sph_eff) * 14'(hpc_eff);

	assign busy = 1'b0;

	logic accept;
	assign accept = start && !busy;

	// Stage 1: the end block and the entry offset.
	logic        v_s1;
	logic [31:0] start_blk_s1;
	logic [31:0] end_blk_s1;
	logic [7:0]  ptype_s1;
	logic [8:0]  offset_s1;
	logic [8:0]  offset_d;

	// Slot zero counts as the first entry, slots above four as the last.
	always_comb begin
		case (slot_number) inside
			3'd0, 3'd1: offset_d = TABLE_BASE;
			3'd2:       offset_d = TABLE_BASE + ENTRY_STRIDE;
			3'd3:       offset_d = TABLE_BASE + 9'(2 * ENTRY_STRIDE);
			default:    offset_d = TABLE_BASE + 9'(3 * ENTRY_STRIDE);
		endcase
	end

	// Stage 2: saturated blocks become sector addresses.
	logic        v_s2;
	logic [31:0] a_lba_s2;
	logic [31:0] b_lba_s2;
	logic [7:0]  ptype_s2;
	logic [8:0]  offset_s2;
	logic [29:0] a_sat;
	logic [29:0] b_sat;

	assign a_sat = (start_blk_s1[31:30] != 2'b00) ? BLOCK_MAX : start_blk_s1[29:0];
	assign b_sat = (end_blk_s1[31:30] != 2'b00) ? BLOCK_MAX : end_blk_s1[29:0];

	// Stage 3: cylinder overflow test, sector count, divider setup.
	logic  v_s3;
	lane_t a_s3;
	lane_t b_s3;
	side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		start_blk_s1 <= start_block;
		end_blk_s1   <= start_block + size_blocks;
		ptype_s1     <= part_type_in;
		offset_s1    <= offset_d;

		a_lba_s2  <= {a_sat, 2'b00};
		b_lba_s2  <= {b_sat, 2'b00} - 32'd1;
		ptype_s2  <= ptype_s1;
		offset_s2 <= offset_s1;

		// A cylinder of 1024 or more means the address is at least 1024 cylinders.
		a_s3.ovf <= (a_lba_s2[31:10] >= 22'(per_cyl));
		a_s3.rem <= a_lba_s2[REM_W-1:0];
		a_s3.quo <= '0;
		b_s3.ovf <= (b_lba_s2[31:10] >= 22'(per_cyl));
		b_s3.rem <= b_lba_s2[REM_W-1:0];
		b_s3.quo <= '0;
		side_s3.offset    <= offset_s2;
		side_s3.ptype     <= ptype_s2;
		side_s3.first_lba <= a_lba_s2;
		side_s3.count     <= b_lba_s2 - a_lba_s2 + 32'd1;
	end

	// Divider stages: one restoring step per stage, cylinder bits first.
	function automatic lane_t div_step(lane_t l, logic [REM_W-1:0] dvs,
		logic [DIV_STAGES-1:0] qmask);
		lane_t r;
		r = l;
		if (l.rem >= dvs) begin
			r.rem = l.rem - dvs;
			r.quo = l.quo | qmask;
		end
		return r;
	endfunction

	logic  [DIV_STAGES-1:0] div_v_s;
	lane_t                  div_a_s    [DIV_STAGES];
	lane_t                  div_b_s    [DIV_STAGES];
	side_t                  div_side_s [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
		localparam logic [DIV_STAGES-1:0] QMASK = DIV_STAGES'(1) << (DIV_STAGES - 1 - i);

		logic             v_in;
		lane_t            a_in;
		lane_t            b_in;
		side_t            side_in;
		logic [REM_W-1:0] dvs;

		if (i == 0) begin : g_first
			assign v_in    = v_s3;
			assign a_in    = a_s3;
			assign b_in    = b_s3;
			assign side_in = side_s3;
		end else begin : g_next
			assign v_in    = div_v_s[i-1];
			assign a_in    = div_a_s[i-1];
			assign b_in    = div_b_s[i-1];
			assign side_in = div_side_s[i-1];
		end

		if (i < CYL_BITS) begin : g_cyl
			assign dvs = REM_W'(per_cyl) << (CYL_BITS - 1 - i);
		end else begin : g_head
			assign dvs = REM_W'(sph_eff) << (DIV_STAGES - 1 - i);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[i] <= 1'b0;
			end else begin
				div_v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			div_a_s[i]    <= div_step(a_in, dvs, QMASK);
			div_b_s[i]    <= div_step(b_in, dvs, QMASK);
			div_side_s[i] <= side_in;
		end
	end

	// Output register: clamp, then pack cylinder and sector as MBR does.
	lane_t      a_fin;
	lane_t      b_fin;
	logic [9:0] a_cyl;
	logic [9:0] b_cyl;
	logic [7:0] a_head;
	logic [7:0] b_head;
	logic [5:0] a_sec;
	logic [5:0] b_sec;

	assign a_fin = div_a_s[DIV_STAGES-1];
	assign b_fin = div_b_s[DIV_STAGES-1];

	always_comb begin
		if (a_fin.ovf) begin
			a_cyl  = CYL_MAX;
			a_head = hpc_eff - 8'd1;
			a_sec  = sph_eff;
		end else begin
			a_cyl  = a_fin.quo[DIV_STAGES-1:HEAD_BITS];
			a_head = a_fin.quo[HEAD_BITS-1:0];
			a_sec  = a_fin.rem[5:0] + 6'd1;
		end
		if (b_fin.ovf) begin
			b_cyl  = CYL_MAX;
			b_head = hpc_eff - 8'd1;
			b_sec  = sph_eff;
		end else begin
			b_cyl  = b_fin.quo[DIV_STAGES-1:HEAD_BITS];
			b_head = b_fin.quo[HEAD_BITS-1:0];
			b_sec  = b_fin.rem[5:0] + 6'd1;
		end
	end

	logic        done_q;
	logic [8:0]  offset_q;
	logic [7:0]  first_head_q;
	logic [7:0]  start_sec_cylhi_q;
	logic [7:0]  start_cyl_low_q;
	logic [7:0]  ptype_q;
	logic [7:0]  last_head_q;
	logic [7:0]  end_sec_cylhi_q;
	logic [7:0]  end_cyl_low_q;
	logic [31:0] first_lba_q;
	logic [31:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_v_s[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		offset_q          <= div_side_s[DIV_STAGES-1].offset;
		ptype_q           <= div_side_s[DIV_STAGES-1].ptype;
		first_lba_q       <= div_side_s[DIV_STAGES-1].first_lba;
		count_q           <= div_side_s[DIV_STAGES-1].count;
		first_head_q      <= a_head;
		start_sec_cylhi_q <= {a_cyl[9:8], a_sec};
		start_cyl_low_q   <= a_cyl[7:0];
		last_head_q       <= b_head;
		end_sec_cylhi_q   <= {b_cyl[9:8], b_sec};
		end_cyl_low_q     <= b_cyl[7:0];
	end

	assign done            = done_q;
	assign entry_offset    = offset_q;
	assign boot_flag       = BOOT_NONE;
	assign first_head      = first_head_q;
	assign start_sec_cylhi = start_sec_cylhi_q;
	assign start_cyl_low   = start_cyl_low_q;
	assign part_type_out   = ptype_q;
	assign last_head       = last_head_q;
	assign end_sec_cylhi   = end_sec_cylhi_q;
	assign end_cyl_low     = end_cyl_low_q;
	assign first_lba       = first_lba_q;
	assign lba_count       = count_q;

`ifndef SYNTH
	// Every result comes from a request taken earlier, through the setup, divider and output registers.
	a_done_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result without a matching request");

	// The offset always names one of the four table entries.
	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (entry_offset[3:0] == 4'd14 && entry_offset >= TABLE_BASE &&
			entry_offset <= TABLE_BASE + 9'(3 * ENTRY_STRIDE)))
		else $error("entry offset out of range");

	// Heads stay below the head count, clamped or not.
	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (first_head < hpc_eff && last_head < hpc_eff))
		else $error("head beyond geometry");

	// Sector numbers are one-based and never exceed the track length.
	a_sector_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (start_sec_cylhi[5:0] != 6'd0 && start_sec_cylhi[5:0] <= sph_eff &&
			end_sec_cylhi[5:0] != 6'd0 && end_sec_cylhi[5:0] <= sph_eff))
		else $error("sector beyond geometry");
`endif

endmodule
